>>> design/bpfm_pkg.sv
package bpfm_pkg;

    typedef enum logic [2:0] {
        MODE_FETCH = 3'd0,
        MODE_NEW   = 3'd1,
        MODE_REL   = 3'd2,
        MODE_FLUSH = 3'd3,
        MODE_FALL  = 3'd4
    } t_mode;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_UNDERFLW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PICK,
        S_ACT,
        S_SCAN
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture request
        logic look;     // register tag match result
        logic pick;     // register victim choice
        logic act;      // apply update and emit result
        logic scan;     // flush-all step
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

>>> design/bpfm_ctrl.sv
module bpfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [2:0]     i_mode,
    input  bpfm_pkg::t_sts i_sts,
    output bpfm_pkg::t_cmd o_cmd
);
    import bpfm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_mode == MODE_FALL) ? S_SCAN : S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_ACT;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_done) |=> r_state == S_IDLE)
        else $error("scan did not end");
    a_look_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |=> r_state == S_PICK)
        else $error("look not followed by pick");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("several commands at once");
`endif
endmodule

>>> design/bpfm_dp.sv
module bpfm_dp #(
    parameter int FRAMES   = 16,
    parameter int ID_BITS  = 32,
    parameter int PIN_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpfm_pkg::t_cmd i_cmd,
    output bpfm_pkg::t_sts o_sts,
    input  logic [2:0]     i_mode,
    input  logic [31:0]    i_blk_id,
    input  logic [31:0]    i_fresh_blk_id,
    input  logic           i_mark_dirty,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [3:0]     o_frame_index,
    output logic           o_hit,
    output logic           o_read_needed,
    output logic           o_zero_fill,
    output logic           o_writeback_valid,
    output logic [31:0]    o_writeback_blk_id,
    output logic [3:0]     o_writeback_frame,
    output logic           o_last
);
    import bpfm_pkg::*;

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LW = $clog2(FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    logic [ID_BITS-1:0]  r_tag   [FRAMES];
    logic [FRAMES-1:0]   r_used;
    logic [PIN_BITS-1:0] r_pin   [FRAMES];
    logic [FRAMES-1:0]   r_dirty;
    // Recency as an age per frame: 0 is least recent among used frames.
    logic [LW-1:0]       r_age   [FRAMES];
    logic [LW-1:0]       r_len;

    logic [2:0]          r_mode;
    logic [ID_BITS-1:0]  r_id;
    logic                r_md;
    logic                r_found;
    logic [FW-1:0]       r_hitf;
    logic                r_pok;
    logic [FW-1:0]       r_pf;
    logic                r_pfree;
    logic [FW-1:0]       r_scan;
    logic                r_any;

    // Tag match.
    logic          m_found;
    logic [FW-1:0] m_f;
    always_comb begin
        m_found = 1'b0;
        m_f     = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_used[i] && r_tag[i] == r_id) begin
                m_found = 1'b1;
                m_f     = FW'(i);
            end
        end
    end

    // Lowest free frame, else oldest unpinned used frame. Ages of used frames
    // are distinct, so the oldest candidate is the one that no other candidate
    // undercuts; every pair is compared side by side.
    logic              p_free, p_old;
    logic [FW-1:0]     p_ff, p_of;
    logic [FRAMES-1:0] p_cand, p_min;
    always_comb begin
        p_free = 1'b0;
        p_ff   = '0;
        p_of   = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                p_free = 1'b1;
                p_ff   = FW'(i);
            end
        end
        for (int i = 0; i < FRAMES; i++)
            p_cand[i] = r_used[i] && r_pin[i] == '0;
        for (int i = 0; i < FRAMES; i++) begin
            p_min[i] = p_cand[i];
            for (int j = 0; j < FRAMES; j++)
                if (p_cand[j] && r_age[j] < r_age[i]) p_min[i] = 1'b0;
        end
        p_old = |p_cand;
        for (int i = FRAMES - 1; i >= 0; i--)
            if (p_min[i]) p_of = FW'(i);
    end

    logic [FW-1:0] a_f;
    logic [LW-1:0] a_old;
    logic          last_dirty;
    assign a_f   = r_found ? r_hitf : r_pf;
    assign a_old = r_age[a_f];
    always_comb begin
        last_dirty = 1'b1;
        for (int i = 0; i < FRAMES; i++)
            if (FW'(i) > r_scan && r_used[i] && r_dirty[i]) last_dirty = 1'b0;
    end
    assign o_sts.scan_done = (r_scan == FW'(FRAMES - 1));

    logic touch;
    assign touch   = (r_mode == MODE_FETCH || r_mode == MODE_NEW) && (r_found || r_pok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_dirty <= '0;
            r_len   <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < FRAMES; i++) r_pin[i] <= '0;
        end else begin
            o_valid <= 1'b0;
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_id   <= (i_mode == MODE_NEW) ? ID_BITS'(i_fresh_blk_id)
                                               : ID_BITS'(i_blk_id);
                r_md   <= i_mark_dirty;
                r_scan <= '0;
                r_any  <= 1'b0;
            end
            if (i_cmd.look) begin
                r_found <= m_found;
                r_hitf  <= m_f;
            end
            if (i_cmd.pick) begin
                r_pok   <= p_free | p_old;
                r_pfree <= p_free;
                r_pf    <= p_free ? p_ff : p_of;
            end
            if (i_cmd.act) begin
                o_valid              <= 1'b1;
                o_last               <= 1'b1;
                o_status             <= ST_OK;
                o_frame_index        <= '0;
                o_hit                <= 1'b0;
                o_read_needed        <= 1'b0;
                o_zero_fill          <= 1'b0;
                o_writeback_valid    <= 1'b0;
                o_writeback_blk_id   <= '0;
                o_writeback_frame    <= '0;
                if (touch) begin
                    // Move to most recent: frames younger than a_f shift down.
                    for (int i = 0; i < FRAMES; i++)
                        if (r_used[i] && r_age[i] > a_old && (r_found || !r_pfree))
                            r_age[i] <= r_age[i] - 1'b1;
                    if (r_found || !r_pfree) r_age[a_f] <= r_len - 1'b1;
                    else begin
                        r_age[a_f] <= r_len;
                        r_len      <= r_len + 1'b1;
                    end
                    o_frame_index <= 4'(a_f);
                end
                unique case (r_mode)
                    MODE_FETCH, MODE_NEW: begin
                        if (r_found) begin
                            if (r_mode == MODE_FETCH) begin
                                if (r_pin[a_f] != PIN_MAX) r_pin[a_f] <= r_pin[a_f] + 1'b1;
                                o_hit <= 1'b1;
                            end else begin
                                r_pin[a_f]   <= PIN_BITS'(1);
                                r_dirty[a_f] <= 1'b0;
                                o_zero_fill  <= 1'b1;
                            end
                        end else if (!r_pok) begin
                            o_status <= ST_FULL;
                        end else begin
                            r_tag[a_f]    <= r_id;
                            r_used[a_f]   <= 1'b1;
                            r_pin[a_f]    <= PIN_BITS'(1);
                            r_dirty[a_f]  <= 1'b0;
                            o_read_needed <= (r_mode == MODE_FETCH);
                            o_zero_fill   <= (r_mode == MODE_NEW);
                            if (!r_pfree && r_dirty[a_f]) begin
                                o_writeback_valid  <= 1'b1;
                                o_writeback_blk_id <= 32'(r_tag[a_f]);
                                o_writeback_frame  <= 4'(a_f);
                            end
                        end
                    end
                    MODE_REL: begin
                        if (!r_found) o_status <= ST_ABSENT;
                        else begin
                            o_frame_index <= 4'(r_hitf);
                            if (r_pin[r_hitf] == '0) o_status <= ST_UNDERFLW;
                            else begin
                                r_pin[r_hitf] <= r_pin[r_hitf] - 1'b1;
                                if (r_md) r_dirty[r_hitf] <= 1'b1;
                            end
                        end
                    end
                    MODE_FLUSH: begin
                        if (!r_found) o_status <= ST_ABSENT;
                        else begin
                            o_frame_index <= 4'(r_hitf);
                            if (r_dirty[r_hitf]) begin
                                r_dirty[r_hitf]    <= 1'b0;
                                o_writeback_valid  <= 1'b1;
                                o_writeback_blk_id <= 32'(r_tag[r_hitf]);
                                o_writeback_frame  <= 4'(r_hitf);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan) begin
                r_scan <= r_scan + 1'b1;
                if (r_used[r_scan] && r_dirty[r_scan]) begin
                    r_dirty[r_scan]      <= 1'b0;
                    r_any                <= 1'b1;
                    o_valid              <= 1'b1;
                    o_last               <= last_dirty;
                    o_status             <= ST_OK;
                    o_frame_index        <= 4'(r_scan);
                    o_hit                <= 1'b0;
                    o_read_needed        <= 1'b0;
                    o_zero_fill          <= 1'b0;
                    o_writeback_valid    <= 1'b1;
                    o_writeback_blk_id   <= 32'(r_tag[r_scan]);
                    o_writeback_frame    <= 4'(r_scan);
                end else if (o_sts.scan_done && !r_any) begin
                    o_valid              <= 1'b1;
                    o_last               <= 1'b1;
                    o_status             <= ST_OK;
                    o_frame_index        <= '0;
                    o_hit                <= 1'b0;
                    o_read_needed        <= 1'b0;
                    o_zero_fill          <= 1'b0;
                    o_writeback_valid    <= 1'b0;
                    o_writeback_blk_id   <= '0;
                    o_writeback_frame    <= '0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len == LW'($countones(r_used)))
        else $error("recency length disagrees with used frames");
    a_act_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act |=> o_valid && o_last)
        else $error("request gave no final result");
    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_used[r_scan] && r_dirty[r_scan]) |=> !r_dirty[$past(r_scan)])
        else $error("flushed frame still dirty");
`endif
endmodule

>>> design/buffer_pool_frame_manager.sv
// Channel   Direction  Handshake          Fields
// request   in         start & !busy      mode, blk_id, fresh_blk_id, mark_dirty
// result    out        o_valid strobe     status .. last
//
// A request runs through capture, tag match, victim pick and update with result.
// Flush all walks one frame per cycle in the frame scan. Reset is synchronous,
// active low, and empties the pool.
// Results appear for one cycle on o_valid; the receiver cannot stall them.
module buffer_pool_frame_manager #(
    parameter int FRAMES   = 16,
    parameter int ID_BITS  = 32,
    parameter int PIN_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_blk_id,
    input  logic [31:0] i_fresh_blk_id,
    input  logic        i_mark_dirty,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_frame_index,
    output logic        o_hit,
    output logic        o_read_needed,
    output logic        o_zero_fill,
    output logic        o_writeback_valid,
    output logic [31:0] o_writeback_blk_id,
    output logic [3:0]  o_writeback_frame,
    output logic        o_last
);
    import bpfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences each request; the datapath holds all frame state.
    bpfm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_sts(sts), .o_cmd(cmd)
    );

    bpfm_dp #(.FRAMES(FRAMES), .ID_BITS(ID_BITS), .PIN_BITS(PIN_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_mode(i_mode), .i_blk_id(i_blk_id),
        .i_fresh_blk_id(i_fresh_blk_id), .i_mark_dirty(i_mark_dirty),
        .o_valid(o_valid), .o_status(o_status), .o_frame_index(o_frame_index),
        .o_hit(o_hit), .o_read_needed(o_read_needed), .o_zero_fill(o_zero_fill),
        .o_writeback_valid(o_writeback_valid),
        .o_writeback_blk_id(o_writeback_blk_id),
        .o_writeback_frame(o_writeback_frame), .o_last(o_last)
    );
endmodule

>>> test/buffer_pool_frame_manager_checker.sv
`timescale 1ns / 1ps

module buffer_pool_frame_manager_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_blk_id,
    input  logic [31:0] i_fresh_blk_id,
    input  logic        i_mark_dirty,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [3:0]  o_frame_index,
    input  logic        o_hit,
    input  logic        o_read_needed,
    input  logic        o_zero_fill,
    input  logic        o_writeback_valid,
    input  logic [31:0] o_writeback_blk_id,
    input  logic [3:0]  o_writeback_frame,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import bpfm_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame;
        logic        hit;
        logic        rd;
        logic        zf;
        logic        wbv;
        logic [31:0] wbid;
        logic [3:0]  wbf;
        logic        last;
    } t_frame_result;

    localparam int NFR = 16;
    localparam logic [7:0] PIN_TOP = 8'hFF;

    t_frame_result pool_results[$];
    logic [31:0] tag_q [NFR];
    logic        used_q[NFR];
    logic [7:0]  pin_q [NFR];
    logic        dirty_q[NFR];
    logic [3:0]  lru_q[$];

    function automatic void queue_result(t_frame_result r);
        pool_results.insert(pool_results.size(), r);
    endfunction

    function automatic void lru_append(int f);
        lru_q.insert(lru_q.size(), f[3:0]);
    endfunction

    function automatic int find_frame(logic [31:0] id);
        for (int i = 0; i < NFR; i++)
            if (used_q[i] && tag_q[i] == id) return i;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        for (int i = 0; i < lru_q.size(); i++)
            if (lru_q[i] == f) begin
                lru_q.delete(i);
                return;
            end
    endfunction

    function automatic t_frame_result blank_result(logic [1:0] st, int f);
        t_frame_result r;
        r = '0;
        r.status = st;
        r.frame = f[3:0];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void place_block(logic [31:0] id, logic is_new);
        t_frame_result r;
        int f;
        logic wb;
        logic [31:0] wid;
        f = -1;
        wb = 1'b0;
        wid = '0;
        for (int i = 0; i < NFR && f < 0; i++)
            if (!used_q[i]) f = i;
        if (f < 0) begin
            for (int i = 0; i < lru_q.size() && f < 0; i++)
                if (pin_q[lru_q[i]] == 0) f = lru_q[i];
            if (f >= 0) begin
                if (dirty_q[f]) begin
                    wb = 1'b1;
                    wid = tag_q[f];
                end
                lru_drop(f);
            end
        end
        if (f < 0) begin
            queue_result(blank_result(ST_FULL, 0));
            return;
        end
        tag_q[f] = id;
        used_q[f] = 1'b1;
        pin_q[f] = 8'd1;
        dirty_q[f] = 1'b0;
        lru_append(f);
        r = blank_result(ST_OK, f);
        r.rd = !is_new;
        r.zf = is_new;
        r.wbv = wb;
        r.wbid = wid;
        r.wbf = wb ? f[3:0] : 4'd0;
        queue_result(r);
    endfunction

    // Predict the results of one accepted request and queue them.
    function automatic void predict_request(logic [2:0] mode, logic [31:0] id,
                                            logic [31:0] fresh, logic md);
        t_frame_result r;
        int f;
        int k;
        case (mode)
            MODE_FETCH: begin
                f = find_frame(id);
                if (f >= 0) begin
                    if (pin_q[f] != PIN_TOP) pin_q[f]++;
                    lru_drop(f);
                    lru_append(f);
                    r = blank_result(ST_OK, f);
                    r.hit = 1'b1;
                    queue_result(r);
                end else place_block(id, 1'b0);
            end
            MODE_NEW: begin
                f = find_frame(fresh);
                if (f >= 0) begin
                    pin_q[f] = 8'd1;
                    dirty_q[f] = 1'b0;
                    lru_drop(f);
                    lru_append(f);
                    r = blank_result(ST_OK, f);
                    r.zf = 1'b1;
                    queue_result(r);
                end else place_block(fresh, 1'b1);
            end
            MODE_REL: begin
                f = find_frame(id);
                if (f < 0) queue_result(blank_result(ST_ABSENT, 0));
                else if (pin_q[f] == 0) queue_result(blank_result(ST_UNDERFLW, f));
                else begin
                    pin_q[f]--;
                    if (md) dirty_q[f] = 1'b1;
                    queue_result(blank_result(ST_OK, f));
                end
            end
            MODE_FLUSH: begin
                f = find_frame(id);
                if (f < 0) queue_result(blank_result(ST_ABSENT, 0));
                else begin
                    r = blank_result(ST_OK, f);
                    if (dirty_q[f]) begin
                        dirty_q[f] = 1'b0;
                        r.wbv = 1'b1;
                        r.wbid = tag_q[f];
                        r.wbf = f[3:0];
                    end
                    queue_result(r);
                end
            end
            MODE_FALL: begin
                k = 0;
                for (int i = 0; i < NFR; i++)
                    if (used_q[i] && dirty_q[i]) begin
                        dirty_q[i] = 1'b0;
                        r = blank_result(ST_OK, i);
                        r.last = 1'b0;
                        r.wbv = 1'b1;
                        r.wbid = tag_q[i];
                        r.wbf = i[3:0];
                        queue_result(r);
                        k++;
                    end
                if (k == 0) queue_result(blank_result(ST_OK, 0));
                else pool_results[pool_results.size() - 1].last = 1'b1;
            end
            default: queue_result(blank_result(ST_OK, 0));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_result e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < NFR; i++) begin
                tag_q[i] = '0;
                used_q[i] = 1'b0;
                pin_q[i] = '0;
                dirty_q[i] = 1'b0;
            end
            pool_results.delete();
            lru_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_pending <= 0;
        end else begin
            // The result is checked before the request of the same edge is
            // predicted; a result always comes after its request.
            if (o_valid) begin
                o_result_count <= o_result_count + 1;
                if (pool_results.size() == 0) begin
                    $error("result with nothing expected");
                    errs++;
                end else begin
                    e = pool_results.pop_front();
                    if (e.status != o_status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        errs++;
                    end
                    if (e.frame != o_frame_index) begin
                        $error("frame_index exp %0d got %0d", e.frame, o_frame_index);
                        errs++;
                    end
                    if (e.hit != o_hit) begin
                        $error("hit exp %0d got %0d", e.hit, o_hit);
                        errs++;
                    end
                    if (e.rd != o_read_needed) begin
                        $error("read_needed exp %0d got %0d", e.rd, o_read_needed);
                        errs++;
                    end
                    if (e.zf != o_zero_fill) begin
                        $error("zero_fill exp %0d got %0d", e.zf, o_zero_fill);
                        errs++;
                    end
                    if (e.wbv != o_writeback_valid) begin
                        $error("writeback_valid exp %0d got %0d", e.wbv, o_writeback_valid);
                        errs++;
                    end
                    if (e.wbid != o_writeback_blk_id) begin
                        $error("writeback_blk_id exp %h got %h", e.wbid,
                               o_writeback_blk_id);
                        errs++;
                    end
                    if (e.wbf != o_writeback_frame) begin
                        $error("writeback_frame exp %0d got %0d", e.wbf, o_writeback_frame);
                        errs++;
                    end
                    if (e.last != o_last) begin
                        $error("last exp %0d got %0d", e.last, o_last);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                predict_request(i_mode, i_blk_id, i_fresh_blk_id, i_mark_dirty);
            o_fail_count <= o_fail_count + errs;
            o_pending <= pool_results.size();
        end
    end
endmodule

>>> test/buffer_pool_frame_manager_tb.sv
`timescale 1ns / 1ps

module buffer_pool_frame_manager_tb;
    import bpfm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_mode;
    logic [31:0] i_blk_id;
    logic [31:0] i_fresh_blk_id;
    logic        i_mark_dirty;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_frame_index;
    logic        o_hit;
    logic        o_read_needed;
    logic        o_zero_fill;
    logic        o_writeback_valid;
    logic [31:0] o_writeback_blk_id;
    logic [3:0]  o_writeback_frame;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          result_count;
    int          request_count;

    // A small pool of ids keeps hits, evictions and releases frequent; the
    // two extreme ids are part of it so both ends of the field are resident.
    logic [31:0] id_pool[24];

    buffer_pool_frame_manager u_top (.*);

    buffer_pool_frame_manager_checker u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_blk_id, .i_fresh_blk_id,
        .i_mark_dirty, .o_valid, .o_status, .o_frame_index, .o_hit, .o_read_needed,
        .o_zero_fill, .o_writeback_valid, .o_writeback_blk_id, .o_writeback_frame,
        .o_last, .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold start high until the block takes the item. Start stays high after
    // the accepting edge so a following item can go out with no gap; idle
    // cycles and drain_results drop it.
    task automatic send_item(logic [2:0] mode, logic [31:0] id, logic [31:0] fresh,
                             logic md, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_blk_id <= id;
        i_fresh_blk_id <= fresh;
        i_mark_dirty <= md;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        request_count++;
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(9) == 0) return $urandom();
        return id_pool[$urandom_range(23)];
    endfunction

    // Mostly well-formed work: fetch and new pin frames, release returns
    // them (often dirty), flushes now and then, a rare unknown mode.
    task automatic random_items(int count, int idle_pct);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 35) send_item(MODE_FETCH, pick_id(), $urandom(), 1'($urandom_range(1)),
                                  idle_pct);
            else if (r < 45) send_item(MODE_NEW, $urandom(), pick_id(),
                                       1'($urandom_range(1)), idle_pct);
            else if (r < 80) send_item(MODE_REL, pick_id(), $urandom(),
                                       1'($urandom_range(1)), idle_pct);
            else if (r < 88) send_item(MODE_FLUSH, pick_id(), $urandom(),
                                       1'($urandom_range(1)), idle_pct);
            else if (r < 96) send_item(MODE_FALL, $urandom(), $urandom(),
                                       1'($urandom_range(1)), idle_pct);
            else send_item(3'($urandom_range(7, 5)), $urandom(), $urandom(),
                           1'($urandom_range(1)), idle_pct);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = '0;
        i_blk_id = '0;
        i_fresh_blk_id = '0;
        i_mark_dirty = 1'b0;
        request_count = 0;
        for (int i = 0; i < 24; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-pool flush all and unknown mode, misses,
        // extreme ids, hits, pin underflow, absent release and flush, clean
        // and dirty flush, new on a resident id, then a fully pinned pool.
        send_item(MODE_FALL, 32'd0, 32'd0, 1'b0, 0);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        send_item(MODE_FETCH, 32'h0000_0000, 32'd0, 1'b0, 0);
        send_item(MODE_FETCH, 32'hFFFF_FFFF, 32'd0, 1'b0, 0);
        send_item(MODE_FETCH, 32'h0000_0000, 32'd0, 1'b0, 0);
        send_item(MODE_REL, 32'h0000_0000, 32'd0, 1'b1, 0);
        send_item(MODE_REL, 32'h0000_0000, 32'd0, 1'b0, 0);
        send_item(MODE_REL, 32'h0000_0000, 32'd0, 1'b1, 0);
        send_item(MODE_REL, 32'h1234_5678, 32'd0, 1'b0, 0);
        send_item(MODE_FLUSH, 32'h1234_5678, 32'd0, 1'b0, 0);
        send_item(MODE_FLUSH, 32'h0000_0000, 32'd0, 1'b0, 0);
        send_item(MODE_FLUSH, 32'hFFFF_FFFF, 32'd0, 1'b0, 0);
        send_item(MODE_REL, 32'hFFFF_FFFF, 32'd0, 1'b1, 0);
        send_item(MODE_NEW, 32'd0, 32'hFFFF_FFFF, 1'b0, 0);
        send_item(MODE_NEW, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0, 0);
        for (int i = 0; i < 15; i++) send_item(MODE_FETCH, id_pool[2 + i], 32'd0, 1'b0, 0);
        send_item(MODE_FETCH, 32'hDEAD_BEEF, 32'd0, 1'b0, 0);
        send_item(MODE_NEW, 32'd0, 32'hDEAD_BEEF, 1'b0, 0);
        for (int i = 0; i < 6; i++) send_item(MODE_REL, id_pool[2 + i], 32'd0, 1'b1, 0);
        send_item(MODE_FALL, 32'd0, 32'd0, 1'b0, 0);

        drain_results();
        random_items(45, 31);
        // Hold off until the pool has answered everything so far.
        drain_results();
        random_items(45, 84);
        random_items(30, 0);

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: hits, misses, evictions,",
                 request_count, result_count);
        $display("write-backs, underflow, full pool, unknown modes and flush all.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS buffer_pool_frame_manager");
        end else begin
            $display("FAIL buffer_pool_frame_manager");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL buffer_pool_frame_manager");
        $finish;
    end
endmodule
